/* rtl/wss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, constants and the sponge weight table of the wave stencil core.
// ----------------------------------------------------------------------------
package wss_pkg;

    // grid and sponge limits
    localparam int MAX_ROWS    = 512;
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_SPONGE  = 64;
    localparam int MIN_GRID    = 5;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int SPG_W = $clog2(MAX_SPONGE);
    localparam int RCNT_W = ROW_W + 1;
    localparam int CCNT_W = COL_W + 1;
    localparam int NB_W   = SPG_W + 1;

    // raw register widths
    localparam int REG_COLS_W = 11;
    localparam int REG_ROWS_W = 10;
    localparam int REG_NB_W   = 7;

    // datapath widths (Q8.24)
    localparam int DATA_W   = 32;
    localparam int VEL_W    = 31;
    localparam int WEIGHT_W = 25;
    localparam int FRAC_W   = 24;

    // register indexes
    localparam logic [2:0] REG_GRID_COLUMNS  = 3'd0;
    localparam logic [2:0] REG_GRID_ROWS     = 3'd1;
    localparam logic [2:0] REG_SPONGE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_COEF_CENTER   = 3'd3;
    localparam logic [2:0] REG_COEF_ROW_NEAR = 3'd4;
    localparam logic [2:0] REG_COEF_ROW_FAR  = 3'd5;
    localparam logic [2:0] REG_COEF_COL_NEAR = 3'd6;
    localparam logic [2:0] REG_COEF_COL_FAR  = 3'd7;

    // input opcodes
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_POINT = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CCNT_W-1:0]        cols;
        logic [RCNT_W-1:0]        rows;
        logic [NB_W-1:0]          nb;
        logic signed [DATA_W-1:0] coef_center;
        logic signed [DATA_W-1:0] coef_row_near;
        logic signed [DATA_W-1:0] coef_row_far;
        logic signed [DATA_W-1:0] coef_col_near;
        logic signed [DATA_W-1:0] coef_col_far;
    } cfg_t;

    typedef struct packed {
        logic             en;
        logic [SPG_W-1:0] idx;
    } band_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [COL_W-1:0]         x;
        logic [ROW_W-1:0]         z;
        logic [1:0]               wslot;
        logic                     interior;
        logic                     last;
        band_t                    left;
        band_t                    right;
        band_t                    bottom;
        logic signed [DATA_W-1:0] cin;
        logic signed [DATA_W-1:0] prev;
        logic [VEL_W-1:0]         vel;
    } cmd_t;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t rom_t [MAX_SPONGE];

    // exp(-(0.015k)^2) in Q24, from a 25-term Q30 series, rounded half up
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] xk;
        logic [63:0] term;
        longint      sum;
        logic [63:0] w;
        for (int k = 1; k <= MAX_SPONGE; k++) begin
            xk   = (64'd225 * 64'(k) * 64'(k) * (64'd1 << 30) + 64'd500000) / 64'd1000000;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 24; n++) begin
                term = ((term * xk) >> 30) / 64'(n);
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            w = (64'(sum) + 64'd32) >> 6;
            if (w > (64'd1 << FRAC_W)) begin
                w = 64'd1 << FRAC_W;
            end
            rom[k-1] = WEIGHT_W'(w);
        end
        return rom;
    endfunction

    localparam rom_t SPONGE_ROM = build_rom();

endpackage
`default_nettype wire

/* rtl/wss_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wss_front
// Takes input beats, walks the grid counters and the drain position, and
// turns each beat into a command for the back end (or drops it).
// ----------------------------------------------------------------------------
module wss_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire wss_pkg::cfg_t                  cfg,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_opcode,
    input  wire logic signed [wss_pkg::DATA_W-1:0] s_pressure_prev,
    input  wire logic signed [wss_pkg::DATA_W-1:0] s_pressure_cur,
    input  wire logic [wss_pkg::VEL_W-1:0]      s_vel_term,
    input  wire logic                           q_full,
    output logic                                q_push,
    output wss_pkg::cmd_t                       q_data
);

    logic [wss_pkg::ROW_W-1:0] in_row_reg;
    logic [wss_pkg::COL_W-1:0] in_col_reg;
    logic [wss_pkg::ROW_W-1:0] out_row_reg;
    logic [wss_pkg::COL_W-1:0] out_col_reg;
    logic                      drain_reg;

    logic                       accept;
    logic                       is_point;
    logic                       in_row_wrap;
    logic                       in_col_wrap;
    logic                       out_row_wrap;
    logic [wss_pkg::CCNT_W-1:0] out_col_inc;
    logic                       out_col_wrap;
    logic [wss_pkg::COL_W-1:0]  cx;
    logic [wss_pkg::ROW_W-1:0]  cz;

    // sponge band lookup from the distance to an edge
    function automatic wss_pkg::band_t band_of(input logic [wss_pkg::CCNT_W-1:0] span,
                                               input logic [wss_pkg::NB_W-1:0] nb,
                                               input logic inside_grid);
        wss_pkg::band_t b;
        logic [wss_pkg::NB_W-1:0] d;
        d     = nb - wss_pkg::NB_W'(span) - wss_pkg::NB_W'(1);
        b.en  = inside_grid && (span < wss_pkg::CCNT_W'(nb));
        b.idx = d[wss_pkg::SPG_W-1:0];
        return b;
    endfunction

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_point = (s_opcode == wss_pkg::OP_POINT);

    // counter wraps
    assign in_row_wrap  = (wss_pkg::RCNT_W'(in_row_reg) + wss_pkg::RCNT_W'(1)) >= cfg.rows;
    assign in_col_wrap  = (wss_pkg::CCNT_W'(in_col_reg) + wss_pkg::CCNT_W'(1)) >= cfg.cols;
    assign out_row_wrap = (wss_pkg::RCNT_W'(out_row_reg) + wss_pkg::RCNT_W'(1)) >= cfg.rows;
    assign out_col_inc  = wss_pkg::CCNT_W'(out_col_reg) + wss_pkg::CCNT_W'(1);
    assign out_col_wrap = out_col_inc >= cfg.cols;

    assign cx = is_point ? (in_col_reg - wss_pkg::COL_W'(2)) : out_col_reg;
    assign cz = is_point ? in_row_reg : out_row_reg;

    // classify the beat
    always_comb begin
        q_push = accept && (is_point ? !drain_reg : drain_reg);
        if (!is_point) begin
            q_data.kind = wss_pkg::CMD_DRAIN;
        end else if (in_col_reg >= wss_pkg::COL_W'(2)) begin
            q_data.kind = wss_pkg::CMD_POINT;
        end else begin
            q_data.kind = wss_pkg::CMD_STORE;
        end
        q_data.x        = cx;
        q_data.z        = cz;
        q_data.wslot    = in_col_reg[1:0];
        q_data.interior = is_point
                          && (cx >= wss_pkg::COL_W'(2))
                          && ((wss_pkg::CCNT_W'(cx) + wss_pkg::CCNT_W'(2)) < cfg.cols)
                          && (cz >= wss_pkg::ROW_W'(2))
                          && ((wss_pkg::RCNT_W'(cz) + wss_pkg::RCNT_W'(2)) < cfg.rows);
        q_data.last     = !is_point && out_row_wrap && out_col_wrap;
        q_data.left     = band_of(wss_pkg::CCNT_W'(cx), cfg.nb, 1'b1);
        q_data.right    = band_of(cfg.cols - wss_pkg::CCNT_W'(1) - wss_pkg::CCNT_W'(cx),
                                  cfg.nb, wss_pkg::CCNT_W'(cx) < cfg.cols);
        q_data.bottom   = band_of(wss_pkg::CCNT_W'(cfg.rows - wss_pkg::RCNT_W'(1)
                                                  - wss_pkg::RCNT_W'(cz)),
                                  cfg.nb, wss_pkg::RCNT_W'(cz) < cfg.rows);
        q_data.cin      = s_pressure_cur;
        q_data.prev     = s_pressure_prev;
        q_data.vel      = s_vel_term;
    end

    // grid walk and drain position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            drain_reg   <= 1'b0;
        end else if (q_push && is_point) begin
            if (in_row_wrap) begin
                in_row_reg <= '0;
                if (in_col_wrap) begin
                    in_col_reg  <= '0;
                    drain_reg   <= 1'b1;
                    out_col_reg <= wss_pkg::COL_W'(cfg.cols - wss_pkg::CCNT_W'(2));
                    out_row_reg <= '0;
                end else begin
                    in_col_reg <= in_col_reg + wss_pkg::COL_W'(1);
                end
            end else begin
                in_row_reg <= in_row_reg + wss_pkg::ROW_W'(1);
            end
        end else if (q_push) begin
            if (out_row_wrap) begin
                out_row_reg <= '0;
                if (out_col_wrap) begin
                    drain_reg   <= 1'b0;
                    out_col_reg <= '0;
                end else begin
                    out_col_reg <= out_col_inc[wss_pkg::COL_W-1:0];
                end
            end else begin
                out_row_reg <= out_row_reg + wss_pkg::ROW_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/wss_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wss_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module wss_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire wss_pkg::cmd_t push_data,
    input  wire logic          pop,
    output wss_pkg::cmd_t      head,
    output logic               empty,
    output logic               full
);

    wss_pkg::cmd_t               entry_reg [wss_pkg::QUEUE_DEPTH];
    logic [wss_pkg::QPTR_W:0]    wr_ptr_reg;
    logic [wss_pkg::QPTR_W:0]    rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[wss_pkg::QPTR_W-1:0] == rd_ptr_reg[wss_pkg::QPTR_W-1:0])
                   && (wr_ptr_reg[wss_pkg::QPTR_W] != rd_ptr_reg[wss_pkg::QPTR_W]);
    assign head  = entry_reg[rd_ptr_reg[wss_pkg::QPTR_W-1:0]];

    // storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg[wss_pkg::QPTR_W-1:0]] <= push_data;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + (wss_pkg::QPTR_W+1)'(1);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + (wss_pkg::QPTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/wss_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wss_back
// Line buffers, stencil sequencer, update, sponge damping and result register.
// One command at a time; one cur read per cycle and at most two multiplies.
// ----------------------------------------------------------------------------
module wss_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire wss_pkg::cfg_t                     cfg,
    input  wire logic                              q_valid,
    input  wire wss_pkg::cmd_t                     q_head,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [wss_pkg::DATA_W-1:0]      m_pressure_next,
    output logic signed [wss_pkg::DATA_W-1:0]      m_pressure_damped,
    output logic                                   m_saturated,
    output logic                                   m_last_point
);

    localparam int CUR_AW = wss_pkg::ROW_W + 2;
    localparam int DLY_AW = wss_pkg::ROW_W + 1;
    localparam int CUR_DEPTH = 4 * wss_pkg::MAX_ROWS;
    localparam int DLY_DEPTH = 2 * wss_pkg::MAX_ROWS;
    localparam int ACC_W = 60;
    localparam int WIDE_W = 66;
    localparam int DPROD_W = wss_pkg::DATA_W + wss_pkg::WEIGHT_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_RND   = 4'd4;
    localparam logic [3:0] S_VMUL  = 4'd5;
    localparam logic [3:0] S_NEXT  = 4'd6;
    localparam logic [3:0] S_DW    = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_DRND  = 4'd9;
    localparam logic [3:0] S_WRITE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [3:0] LAST_TERM = 4'd8;
    localparam logic [1:0] LAST_BAND = 2'd2;

    // line buffers
    logic [wss_pkg::DATA_W-1:0] cur_mem  [CUR_DEPTH];
    logic [wss_pkg::DATA_W-1:0] prev_mem [DLY_DEPTH];
    logic [wss_pkg::VEL_W-1:0]  vel_mem  [DLY_DEPTH];

    logic signed [wss_pkg::DATA_W-1:0] cur_rdata_reg;
    logic signed [wss_pkg::DATA_W-1:0] prev_rdata_reg;
    logic [wss_pkg::VEL_W-1:0]         vel_rdata_reg;

    logic [3:0]                        state_reg;
    wss_pkg::cmd_t                     cmd_reg;
    logic [3:0]                        term_reg;
    logic [1:0]                        band_reg;
    logic signed [wss_pkg::DATA_W-1:0] cur_reg;
    logic signed [wss_pkg::DATA_W-1:0] prev_reg;
    logic [wss_pkg::VEL_W-1:0]         vel_reg;
    logic signed [wss_pkg::DATA_W-1:0] val_reg;
    logic signed [63:0]                prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [wss_pkg::DATA_W-1:0] tmp_reg;
    logic signed [63:0]                vprod_reg;
    logic                              sat_reg;
    logic [wss_pkg::WEIGHT_W-1:0]      w_reg;
    logic signed [DPROD_W-1:0]         dprod_a_reg;
    logic signed [DPROD_W-1:0]         dprod_b_reg;
    logic                              m_valid_reg;

    logic [CUR_AW-1:0]                 cur_raddr;
    logic [DLY_AW-1:0]                 dly_raddr;
    logic [1:0]                        col_sel;
    logic [wss_pkg::ROW_W-1:0]         row_sel;
    logic signed [wss_pkg::DATA_W-1:0] coef_sel;
    logic signed [wss_pkg::DATA_W-1:0] operand;
    logic signed [ACC_W-1:0]           acc_next;
    logic signed [WIDE_W-1:0]          rnd_wide;
    logic signed [WIDE_W-1:0]          upd_wide;
    logic signed [WIDE_W-1:0]          new_wide;
    logic [wss_pkg::DATA_W:0]          tmp_sat;
    logic [wss_pkg::DATA_W:0]          new_sat;
    wss_pkg::band_t                    band_sel;
    logic                              out_free;

    // clip to 32 bits; top bit of the result is the clip flag
    function automatic logic [wss_pkg::DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] pos;
        logic signed [WIDE_W-1:0] neg;
        logic [wss_pkg::DATA_W:0] r;
        pos = WIDE_W'($signed({1'b0, {(wss_pkg::DATA_W-1){1'b1}}}));
        neg = WIDE_W'($signed({1'b1, {(wss_pkg::DATA_W-1){1'b0}}}));
        if (v > pos) begin
            r = {1'b1, pos[wss_pkg::DATA_W-1:0]};
        end else if (v < neg) begin
            r = {1'b1, neg[wss_pkg::DATA_W-1:0]};
        end else begin
            r = {1'b0, v[wss_pkg::DATA_W-1:0]};
        end
        return r;
    endfunction

    // damped product back to Q24, rounded half up
    function automatic logic signed [wss_pkg::DATA_W-1:0] wround(
            input logic signed [DPROD_W-1:0] p);
        logic signed [DPROD_W-1:0] s;
        s = (p + DPROD_W'(1 <<< (wss_pkg::FRAC_W-1))) >>> wss_pkg::FRAC_W;
        return s[wss_pkg::DATA_W-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;

    // stencil term select: address and coefficient
    always_comb begin
        case (term_reg)
            4'd0: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z;
                        coef_sel = cfg.coef_center; end
            4'd1: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z - wss_pkg::ROW_W'(1);
                        coef_sel = cfg.coef_row_near; end
            4'd2: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z + wss_pkg::ROW_W'(1);
                        coef_sel = cfg.coef_row_near; end
            4'd3: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z - wss_pkg::ROW_W'(2);
                        coef_sel = cfg.coef_row_far; end
            4'd4: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z + wss_pkg::ROW_W'(2);
                        coef_sel = cfg.coef_row_far; end
            4'd5: begin col_sel = cmd_reg.x[1:0] - 2'd1;
                        row_sel = cmd_reg.z;
                        coef_sel = cfg.coef_col_near; end
            4'd6: begin col_sel = cmd_reg.x[1:0] + 2'd1;
                        row_sel = cmd_reg.z;
                        coef_sel = cfg.coef_col_near; end
            4'd7: begin col_sel = cmd_reg.x[1:0] - 2'd2;
                        row_sel = cmd_reg.z;
                        coef_sel = cfg.coef_col_far; end
            default: begin col_sel = cmd_reg.x[1:0];
                        row_sel = cmd_reg.z;
                        coef_sel = cfg.coef_col_far; end
        endcase
        cur_raddr = {col_sel, row_sel};
        dly_raddr = {cmd_reg.x[0], cmd_reg.z};
        operand   = (term_reg == LAST_TERM) ? cmd_reg.cin : cur_rdata_reg;
    end

    // accumulate, round and update arithmetic
    always_comb begin
        acc_next = ((term_reg == 4'd0) ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg >>> 8);
        rnd_wide = WIDE_W'((WIDE_W'(acc_reg) + WIDE_W'(1 <<< 15)) >>> 16);
        tmp_sat  = sat32(rnd_wide);
        upd_wide = WIDE_W'((WIDE_W'(vprod_reg) + WIDE_W'(1 <<< (wss_pkg::FRAC_W-1)))
                           >>> wss_pkg::FRAC_W);
        new_wide = (WIDE_W'(cur_reg) <<< 1) - WIDE_W'(prev_reg) + upd_wide;
        new_sat  = sat32(new_wide);
    end

    // sponge band select
    always_comb begin
        case (band_reg)
            2'd0:    band_sel = cmd_reg.left;
            2'd1:    band_sel = cmd_reg.right;
            default: band_sel = cmd_reg.bottom;
        endcase
    end

    // line buffer reads
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            cur_rdata_reg  <= cur_mem[cur_raddr];
            prev_rdata_reg <= prev_mem[dly_raddr];
            vel_rdata_reg  <= vel_mem[dly_raddr];
        end
    end

    // line buffer writes
    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE && cmd_reg.kind != wss_pkg::CMD_DRAIN) begin
            cur_mem[{cmd_reg.wslot, cmd_reg.z}]     <= cmd_reg.cin;
            prev_mem[{cmd_reg.wslot[0], cmd_reg.z}] <= cmd_reg.prev;
            vel_mem[{cmd_reg.wslot[0], cmd_reg.z}]  <= cmd_reg.vel;
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            term_reg    <= '0;
            band_reg    <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    term_reg <= '0;
                    band_reg <= '0;
                    if (q_valid) begin
                        state_reg <= (q_head.kind == wss_pkg::CMD_STORE) ? S_WRITE : S_READ;
                    end
                end
                S_READ: state_reg <= S_MUL;
                S_MUL: begin
                    if (cmd_reg.kind == wss_pkg::CMD_POINT && cmd_reg.interior) begin
                        state_reg <= S_ACC;
                    end else begin
                        state_reg <= S_DW;
                    end
                end
                S_ACC: begin
                    if (term_reg == LAST_TERM) begin
                        state_reg <= S_RND;
                    end else begin
                        term_reg  <= term_reg + 4'd1;
                        state_reg <= S_READ;
                    end
                end
                S_RND:  state_reg <= S_VMUL;
                S_VMUL: state_reg <= S_NEXT;
                S_NEXT: state_reg <= S_DW;
                S_DW:   state_reg <= S_DMUL;
                S_DMUL: state_reg <= S_DRND;
                S_DRND: begin
                    if (band_reg == LAST_BAND) begin
                        state_reg <= S_WRITE;
                    end else begin
                        band_reg  <= band_reg + 2'd1;
                        state_reg <= S_DW;
                    end
                end
                S_WRITE: begin
                    state_reg <= (cmd_reg.kind == wss_pkg::CMD_STORE) ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    cmd_reg <= q_head;
                end
            end
            S_MUL: begin
                if (term_reg == 4'd0) begin
                    cur_reg  <= cur_rdata_reg;
                    prev_reg <= prev_rdata_reg;
                    vel_reg  <= vel_rdata_reg;
                    val_reg  <= prev_rdata_reg;
                    sat_reg  <= 1'b0;
                end
                prod_reg <= 64'(coef_sel) * 64'(operand);
            end
            S_ACC: acc_reg <= acc_next;
            S_RND: begin
                tmp_reg <= tmp_sat[wss_pkg::DATA_W-1:0];
                sat_reg <= tmp_sat[wss_pkg::DATA_W];
            end
            S_VMUL: vprod_reg <= 64'($signed({1'b0, vel_reg})) * 64'(tmp_reg);
            S_NEXT: begin
                val_reg <= new_sat[wss_pkg::DATA_W-1:0];
                sat_reg <= sat_reg | new_sat[wss_pkg::DATA_W];
            end
            S_DW: begin
                w_reg <= band_sel.en ? wss_pkg::SPONGE_ROM[band_sel.idx]
                                     : wss_pkg::WEIGHT_W'(1 << wss_pkg::FRAC_W);
            end
            S_DMUL: begin
                dprod_a_reg <= DPROD_W'(val_reg) * DPROD_W'($signed({1'b0, w_reg}));
                dprod_b_reg <= DPROD_W'(cur_reg) * DPROD_W'($signed({1'b0, w_reg}));
            end
            S_DRND: begin
                val_reg <= wround(dprod_a_reg);
                cur_reg <= wround(dprod_b_reg);
            end
            S_OUT: begin
                if (out_free) begin
                    m_pressure_next   <= val_reg;
                    m_pressure_damped <= cur_reg;
                    m_saturated       <= sat_reg;
                    m_last_point      <= cmd_reg.last;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

/* rtl/wave_stencil_sponge_step_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wave_stencil_sponge_step_core
// One time step of a 2D fourth-order acoustic wave update with sponge edges.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    opcode, pressure_prev/cur, vel_term
//  m_*       out        m_valid / m_ready    pressure_next/damped, saturated, last
//  cfg_*     in         cfg_wr_en            cfg_index, cfg_wdata
//
//  Beat handling, set by the back-end sequencer (one cur line buffer read per
//  step, at most two multiplies): a point of the first two columns is only
//  stored; a ring point or a drain beat is damped; an interior point runs the
//  stencil terms, the update and the damping. A four-entry command queue takes
//  beats while the back end works. Reset is synchronous, active low; line
//  buffers are not cleared. Output holds its beat until m_ready; the back end waits, the queue fills.
// ----------------------------------------------------------------------------
module wave_stencil_sponge_step_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [2:0]                            cfg_index,
    input  wire logic [wss_pkg::DATA_W-1:0]            cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_opcode,
    input  wire logic signed [wss_pkg::DATA_W-1:0]     s_pressure_prev,
    input  wire logic signed [wss_pkg::DATA_W-1:0]     s_pressure_cur,
    input  wire logic [wss_pkg::VEL_W-1:0]             s_vel_term,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [wss_pkg::DATA_W-1:0]          m_pressure_next,
    output logic signed [wss_pkg::DATA_W-1:0]          m_pressure_damped,
    output logic                                       m_saturated,
    output logic                                       m_last_point
);

    logic [wss_pkg::REG_COLS_W-1:0]    grid_columns_reg;
    logic [wss_pkg::REG_ROWS_W-1:0]    grid_rows_reg;
    logic [wss_pkg::REG_NB_W-1:0]      sponge_width_reg;
    logic signed [wss_pkg::DATA_W-1:0] coef_center_reg;
    logic signed [wss_pkg::DATA_W-1:0] coef_row_near_reg;
    logic signed [wss_pkg::DATA_W-1:0] coef_row_far_reg;
    logic signed [wss_pkg::DATA_W-1:0] coef_col_near_reg;
    logic signed [wss_pkg::DATA_W-1:0] coef_col_far_reg;

    wss_pkg::cfg_t cfg;
    wss_pkg::cmd_t push_data;
    wss_pkg::cmd_t head;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg  <= wss_pkg::REG_COLS_W'(1024);
            grid_rows_reg     <= wss_pkg::REG_ROWS_W'(512);
            sponge_width_reg  <= wss_pkg::REG_NB_W'(30);
            coef_center_reg   <= '0;
            coef_row_near_reg <= '0;
            coef_row_far_reg  <= '0;
            coef_col_near_reg <= '0;
            coef_col_far_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wss_pkg::REG_GRID_COLUMNS:
                    grid_columns_reg <= cfg_wdata[wss_pkg::REG_COLS_W-1:0];
                wss_pkg::REG_GRID_ROWS:
                    grid_rows_reg <= cfg_wdata[wss_pkg::REG_ROWS_W-1:0];
                wss_pkg::REG_SPONGE_WIDTH:
                    sponge_width_reg <= cfg_wdata[wss_pkg::REG_NB_W-1:0];
                wss_pkg::REG_COEF_CENTER:   coef_center_reg   <= cfg_wdata;
                wss_pkg::REG_COEF_ROW_NEAR: coef_row_near_reg <= cfg_wdata;
                wss_pkg::REG_COEF_ROW_FAR:  coef_row_far_reg  <= cfg_wdata;
                wss_pkg::REG_COEF_COL_NEAR: coef_col_near_reg <= cfg_wdata;
                wss_pkg::REG_COEF_COL_FAR:  coef_col_far_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // clamp to the supported grid and sponge range
    always_comb begin
        if (grid_columns_reg < wss_pkg::REG_COLS_W'(wss_pkg::MIN_GRID)) begin
            cfg.cols = wss_pkg::CCNT_W'(wss_pkg::MIN_GRID);
        end else if (grid_columns_reg > wss_pkg::REG_COLS_W'(wss_pkg::MAX_COLUMNS)) begin
            cfg.cols = wss_pkg::CCNT_W'(wss_pkg::MAX_COLUMNS);
        end else begin
            cfg.cols = wss_pkg::CCNT_W'(grid_columns_reg);
        end
        if (grid_rows_reg < wss_pkg::REG_ROWS_W'(wss_pkg::MIN_GRID)) begin
            cfg.rows = wss_pkg::RCNT_W'(wss_pkg::MIN_GRID);
        end else if (grid_rows_reg > wss_pkg::REG_ROWS_W'(wss_pkg::MAX_ROWS)) begin
            cfg.rows = wss_pkg::RCNT_W'(wss_pkg::MAX_ROWS);
        end else begin
            cfg.rows = wss_pkg::RCNT_W'(grid_rows_reg);
        end
        if (sponge_width_reg > wss_pkg::REG_NB_W'(wss_pkg::MAX_SPONGE)) begin
            cfg.nb = wss_pkg::NB_W'(wss_pkg::MAX_SPONGE);
        end else begin
            cfg.nb = wss_pkg::NB_W'(sponge_width_reg);
        end
        cfg.coef_center   = coef_center_reg;
        cfg.coef_row_near = coef_row_near_reg;
        cfg.coef_row_far  = coef_row_far_reg;
        cfg.coef_col_near = coef_col_near_reg;
        cfg.coef_col_far  = coef_col_far_reg;
    end

    wss_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pressure_prev (s_pressure_prev),
        .s_pressure_cur  (s_pressure_cur),
        .s_vel_term      (s_vel_term),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (push_data)
    );

    wss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    wss_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .q_valid           (!q_empty),
        .q_head            (head),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pressure_next   (m_pressure_next),
        .m_pressure_damped (m_pressure_damped),
        .m_saturated       (m_saturated),
        .m_last_point      (m_last_point)
    );

endmodule
`default_nettype wire

/* rtl/wss_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks for the wave stencil core, bound to the top level.
// ----------------------------------------------------------------------------
module wss_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [wss_pkg::DATA_W-1:0] m_pressure_next,
    input wire logic signed [wss_pkg::DATA_W-1:0] m_pressure_damped,
    input wire logic                              m_saturated,
    input wire logic                              m_last_point
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure_next)
                                && $stable(m_pressure_damped) && $stable(m_last_point))
        else $error("result beat changed while stalled");

    // the closing drain beat never carries a clip
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_point |-> !m_saturated)
        else $error("last point flagged saturated");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // reset empties the command queue
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind wave_stencil_sponge_step_core wss_checker u_wss_checker (.*);
`default_nettype wire
